@@ hw/rtl/mrld_pkg.sv @@
// ----------------------------------------------------------------------------
// mrld_pkg
// shared types and constants for the mixed run-length line decoder
// ----------------------------------------------------------------------------
`default_nettype none

package mrld_pkg;

  localparam int unsigned MAX_CHANNELS = 4;
  localparam int unsigned APB_AW       = 4;

  // register byte addresses
  localparam logic [APB_AW-1:0] REG_MODE_ADDR  = 4'h0;
  localparam logic [APB_AW-1:0] REG_CHAN_ADDR  = 4'h4;
  localparam logic [APB_AW-1:0] REG_WIDTH_ADDR = 4'h8;

  // register reset values
  localparam logic [2:0]  CHAN_RESET  = 3'd3;
  localparam logic [15:0] WIDTH_RESET = 16'd512;

  // mixed mode header codes
  localparam logic [7:0] HDR_LONG_RUN = 8'd128;
  localparam logic [7:0] HDR_RUN_BIAS = 8'd127;

  typedef enum logic [1:0] {
    MODE_RAW   = 2'd0,
    MODE_PURE  = 2'd1,
    MODE_MIXED = 2'd2,
    MODE_NONE  = 2'd3
  } enc_mode_e;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LONG_HI = 2'd1,
    PH_LONG_LO = 2'd2,
    PH_COLLECT = 2'd3
  } phase_e;

  typedef struct packed {
    enc_mode_e   mode;
    logic [2:0]  chan;
    logic [15:0] width;
  } cfg_t;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic [15:0] repeat_count;
    logic        end_of_line;
    logic        overrun;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/mixed_rle_line_decoder.sv @@
// ----------------------------------------------------------------------------
// mixed_rle_line_decoder
// byte-stream run-length decoder for one channel packet line
// ----------------------------------------------------------------------------
// Takes one compressed byte per word on the input stream and gives one word
// per finished pixel or run: pixel value, repeat count, end of line on tlast
// and a clipped-run flag on tuser. Modes are uncompressed, pure run-length
// (count byte then value) and mixed run-length (128 then a 16-bit big-endian
// count, 129..255 for runs of header-127, 0..127 for header+1 raw pixels).
// The block accepts one byte every cycle and keeps that rate as long as the
// output side is ready; a byte passes an input register, the decode logic and
// the result register. A fourth mode, none, takes bytes and gives no word.
// Runs of length zero give no word; runs past the line end are cut and
// flagged. Writing any register clears the parse state and line position;
// write only while the block is idle.
`default_nettype none

module mixed_rle_line_decoder (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // config port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mrld_pkg::APB_AW-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // compressed byte stream
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,  // data_byte
  // decoded runs
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [47:0]                       m_axis_tdata,  // pixel_value, repeat_count
  output logic                              m_axis_tlast,  // end_of_line
  output logic                              m_axis_tuser   // overrun
);
  import mrld_pkg::*;

  cfg_t cfg_q;
  logic cfg_wr;
  logic cfg_hit;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       fire;
  logic       emit;
  logic       out_free;
  res_t       step_res;
  res_t       out_res;

  // register writes land on the access phase
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_hit = cfg_wr && ((paddr == REG_MODE_ADDR) || (paddr == REG_CHAN_ADDR) ||
                              (paddr == REG_WIDTH_ADDR));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode  <= MODE_MIXED;
      cfg_q.chan  <= CHAN_RESET;
      cfg_q.width <= WIDTH_RESET;
    end else if (cfg_wr) begin
      case (paddr)
        REG_MODE_ADDR:  cfg_q.mode  <= enc_mode_e'(pwdata[1:0]);
        REG_CHAN_ADDR:  cfg_q.chan  <= pwdata[2:0];
        REG_WIDTH_ADDR: cfg_q.width <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_MODE_ADDR:  prdata = {30'd0, cfg_q.mode};
      REG_CHAN_ADDR:  prdata = {29'd0, cfg_q.chan};
      REG_WIDTH_ADDR: prdata = {16'd0, cfg_q.width};
      default:        prdata = 32'd0;
    endcase
  end

  // input register: a held byte is decoded once the result register has room
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  mrld_step u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .clear_i (cfg_hit),
    .fire_i  (fire),
    .byte_i  (in_byte_q),
    .emit_o  (emit),
    .res_o   (step_res)
  );

  mrld_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && emit),
    .res_i   (step_res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {out_res.repeat_count, out_res.pixel_value};
  assign m_axis_tlast = out_res.end_of_line;
  assign m_axis_tuser = out_res.overrun;

endmodule

`default_nettype wire

@@ hw/rtl/mrld_step.sv @@
// ----------------------------------------------------------------------------
// mrld_step
// parse state and per-byte decode, one byte per cycle while fire_i is high
// ----------------------------------------------------------------------------
`default_nettype none

module mrld_step (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire mrld_pkg::cfg_t cfg_i,
  input  wire logic          clear_i,
  input  wire logic          fire_i,
  input  wire logic [7:0]    byte_i,
  output logic               emit_o,
  output mrld_pkg::res_t     res_o
);
  import mrld_pkg::*;

  phase_e      phase_q, phase_d;
  logic        raw_q, raw_d;
  logic [15:0] left_q, left_d;
  logic [1:0]  bip_q, bip_d;
  logic [31:0] asm_q, asm_d;
  logic [15:0] done_q, done_d;

  logic [2:0]  eff_ch;
  logic [15:0] eff_w;
  logic [31:0] asm_shift;
  logic        col_done;
  logic        want;
  logic [15:0] cnt;
  logic [15:0] remaining;
  logic [15:0] left_dec;
  logic        hit_end;

  always_comb begin
    if (cfg_i.chan == 3'd0) begin
      eff_ch = 3'd1;
    end else if (cfg_i.chan > 3'(MAX_CHANNELS)) begin
      eff_ch = 3'(MAX_CHANNELS);
    end else begin
      eff_ch = cfg_i.chan;
    end
    eff_w = (cfg_i.width == 16'd0) ? 16'd1 : cfg_i.width;
  end

  assign asm_shift = {asm_q[23:0], byte_i};
  assign col_done  = (({1'b0, bip_q}) + 3'd1) >= eff_ch;
  assign left_dec  = (left_q != 16'd0) ? left_q - 16'd1 : left_q;
  assign remaining = eff_w - done_q;

  always_comb begin
    phase_d = phase_q;
    raw_d   = raw_q;
    left_d  = left_q;
    bip_d   = bip_q;
    asm_d   = asm_q;
    want    = 1'b0;
    cnt     = 16'd1;
    case (cfg_i.mode)
      MODE_NONE: begin
      end
      MODE_RAW: begin
        asm_d = col_done ? 32'd0 : asm_shift;
        bip_d = col_done ? 2'd0 : bip_q + 2'd1;
        want  = col_done;
      end
      default: begin
        case (phase_q)
          PH_HEADER: begin
            bip_d = 2'd0;
            asm_d = 32'd0;
            if (cfg_i.mode == MODE_PURE) begin
              left_d  = {8'd0, byte_i};
              raw_d   = 1'b0;
              phase_d = PH_COLLECT;
            end else if (byte_i == HDR_LONG_RUN) begin
              phase_d = PH_LONG_HI;
            end else if (byte_i > HDR_LONG_RUN) begin
              left_d  = {8'd0, byte_i - HDR_RUN_BIAS};
              raw_d   = 1'b0;
              phase_d = PH_COLLECT;
            end else begin
              left_d  = {8'd0, byte_i} + 16'd1;
              raw_d   = 1'b1;
              phase_d = PH_COLLECT;
            end
          end
          PH_LONG_HI: begin
            left_d  = {byte_i, 8'd0};
            phase_d = PH_LONG_LO;
          end
          PH_LONG_LO: begin
            left_d  = {left_q[15:8], byte_i};
            raw_d   = 1'b0;
            phase_d = PH_COLLECT;
          end
          PH_COLLECT: begin
            asm_d = col_done ? 32'd0 : asm_shift;
            bip_d = col_done ? 2'd0 : bip_q + 2'd1;
            if (col_done) begin
              want = 1'b1;
              if (raw_q) begin
                left_d = left_dec;
                if (left_dec == 16'd0) begin
                  phase_d = PH_HEADER;
                end
              end else begin
                cnt     = left_q;
                phase_d = PH_HEADER;
              end
            end
          end
          default: begin
            phase_d = PH_HEADER;
          end
        endcase
      end
    endcase
  end

  // clip the run at the line end
  assign hit_end = cnt >= remaining;
  assign emit_o  = want && (cnt != 16'd0);

  always_comb begin
    res_o.pixel_value  = asm_shift;
    res_o.repeat_count = hit_end ? remaining : cnt;
    res_o.end_of_line  = hit_end;
    res_o.overrun      = cnt > remaining;
    done_d             = done_q;
    if (emit_o) begin
      done_d = hit_end ? 16'd0 : done_q + cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      raw_q   <= 1'b0;
      left_q  <= 16'd0;
      bip_q   <= 2'd0;
      asm_q   <= 32'd0;
      done_q  <= 16'd0;
    end else if (clear_i) begin
      phase_q <= PH_HEADER;
      raw_q   <= 1'b0;
      left_q  <= 16'd0;
      bip_q   <= 2'd0;
      asm_q   <= 32'd0;
      done_q  <= 16'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      raw_q   <= raw_d;
      left_q  <= left_d;
      bip_q   <= bip_d;
      asm_q   <= asm_d;
      done_q  <= done_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mrld_out_reg.sv @@
// ----------------------------------------------------------------------------
// mrld_out_reg
// result register on the output stream
// ----------------------------------------------------------------------------
`default_nettype none

module mrld_out_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire mrld_pkg::res_t res_i,
  output logic                free_o,
  output logic                valid_o,
  input  wire logic           ready_i,
  output mrld_pkg::res_t      res_o
);
  import mrld_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

@@ hw/rtl/mrld_checker.sv @@
// ----------------------------------------------------------------------------
// mrld_checker
// port-level checks for the mixed run-length line decoder
// ----------------------------------------------------------------------------
`default_nettype none

module mrld_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic        m_axis_tuser
);

  // stalled word holds its payload
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // stalled word stays valid
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  // a clipped run always closes the line
  a_ovr_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("overrun without end of line");

  // zero-length runs never reach the output
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[47:32] != 16'd0))
    else $error("zero repeat count on output");

endmodule

bind mixed_rle_line_decoder mrld_checker u_mrld_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
